>>> hw/rtl/ofc_pkg.sv
// Shared types, constants and the CRC-8 byte function for the 1-Wire frame checker.
package ofc_pkg;

  // Channel count and derived index width
  localparam int CHANNELS = 16;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Fixed field widths
  localparam int CH_W    = 4;
  localparam int BYTE_W  = 8;
  localparam int VALUE_W = 64;
  localparam int ERR_W   = 8;
  localparam int HOLD_W  = 16;
  localparam int KINDS_W = 32;

  // Frame layout: eight data bytes, then the received CRC
  localparam logic [3:0] LAST_POS = 4'd8;

  // CRC and special values
  localparam logic [BYTE_W-1:0]  CRC_POLY        = 8'h8C;
  localparam logic [VALUE_W-1:0] TEMP_ERROR_CODE = 64'h0000_0000_0000_FC00;
  localparam logic [VALUE_W-1:0] KEY_EMPTY       = 64'hFFFF_FFFF_FFFF_FFFF;

  // Device kinds
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_TEMP  = 2'd1;
  localparam logic [1:0] KIND_KEY   = 2'd2;
  localparam logic [1:0] KIND_OTHER = 2'd3;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_KINDS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HOLD_COUNT = 2'd2;
  localparam int CFG_DATA_W = 32;

  // Queue depths
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int RESQ_DEPTH = 2;
  localparam int RESQ_PTR_W = (RESQ_DEPTH > 1) ? $clog2(RESQ_DEPTH) : 1;

  // Completed frame handed from front to back
  typedef struct packed {
    logic [CH_W-1:0]    ch;
    logic [VALUE_W-1:0] bytes;
    logic               ok;
  } frame_cmd_t;

  // One result beat
  typedef struct packed {
    logic [CH_W-1:0]           ch;
    logic signed [VALUE_W-1:0] value;
    logic                      crc_ok;
    logic [ERR_W-1:0]          errors;
  } result_t;

  // Configuration write
  typedef struct packed {
    logic                  wr;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // Dallas CRC-8, reflected, one byte unrolled over its eight bits
  function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    c = crc_in;
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[0] ^ b[k]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/ofc_front.sv
// Front end: byte position, running CRC and byte collection; issues one command per frame.
module ofc_front import ofc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic [CH_W-1:0]   in_channel,
  input  logic [BYTE_W-1:0] in_frame_byte,
  output logic              in_full,
  output logic              cmd_push,
  output frame_cmd_t        cmd,
  input  logic              cmd_full
);

  logic [3:0]         pos_r;
  logic [3:0]         pos_nxt;
  logic [BYTE_W-1:0]  crc_r;
  logic [BYTE_W-1:0]  crc_nxt;
  logic [VALUE_W-1:0] bytes_r;
  logic [VALUE_W-1:0] bytes_nxt;
  logic               last;
  logic               accept;

  // Only the closing byte needs room in the command queue
  assign last    = (pos_r >= LAST_POS);
  assign in_full = last && cmd_full;
  assign accept  = in_push && !in_full;

  assign cmd_push  = accept && last;
  assign cmd.ch    = in_channel;
  assign cmd.bytes = bytes_r;
  assign cmd.ok    = (crc_r == in_frame_byte);

  // Next frame state
  always_comb begin
    pos_nxt   = pos_r;
    crc_nxt   = crc_r;
    bytes_nxt = bytes_r;
    if (accept) begin
      if (last) begin
        pos_nxt   = '0;
        crc_nxt   = '0;
        bytes_nxt = '0;
      end else begin
        pos_nxt   = pos_r + 4'd1;
        crc_nxt   = crc8_byte(crc_r, in_frame_byte);
        bytes_nxt = {bytes_r[VALUE_W-BYTE_W-1:0], in_frame_byte};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      crc_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      crc_r <= crc_nxt;
    end
    bytes_r <= bytes_nxt;
  end

endmodule

>>> hw/rtl/ofc_cmd_queue.sv
// Short command queue between the front and back ends.
module ofc_cmd_queue import ofc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  frame_cmd_t push_data,
  output logic       full,
  input  logic       pop,
  output frame_cmd_t head,
  output logic       empty
);

  frame_cmd_t            mem_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r;
  logic [CMDQ_PTR_W-1:0] rd_ptr_r;
  logic [CMDQ_PTR_W:0]   cnt_r;
  logic                  do_push;
  logic                  do_pop;

  assign full    = (cnt_r == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  // Pointer and count update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> hw/rtl/ofc_back.sv
// Back end: configuration, per-channel state update and the result queue.
module ofc_back import ofc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_wr_t    cfg,
  input  frame_cmd_t cmd,
  input  logic       cmd_empty,
  output logic       cmd_pop,
  input  logic       res_pop,
  output result_t    res_head,
  output logic       res_empty
);

  // Configuration registers
  logic [KINDS_W-1:0] kinds_r;
  logic [ERR_W-1:0]   err_limit_r;
  logic [HOLD_W-1:0]  hold_count_r;

  // Per-channel state
  logic [VALUE_W-1:0] value_r [CHANNELS];
  logic [ERR_W-1:0]   errs_r  [CHANNELS];
  logic [HOLD_W-1:0]  timer_r [CHANNELS];

  // Result queue
  result_t               res_mem_r [RESQ_DEPTH];
  logic [RESQ_PTR_W-1:0] res_wr_r;
  logic [RESQ_PTR_W-1:0] res_rd_r;
  logic [RESQ_PTR_W:0]   res_cnt_r;
  logic                  res_full;
  logic                  res_do_pop;

  logic [CH_IDX_W-1:0] ch_idx;
  logic                in_range;
  logic [1:0]          kind;
  logic                go;
  logic [VALUE_W-1:0]  cur_value;
  logic [ERR_W-1:0]    cur_errs;
  logic [HOLD_W-1:0]   cur_timer;
  logic [VALUE_W-1:0]  value_nxt;
  logic [ERR_W-1:0]    errs_nxt;
  logic [HOLD_W-1:0]   timer_nxt;
  logic [15:0]         raw;
  logic signed [19:0]  r_ext;
  logic signed [19:0]  prod;
  logic signed [19:0]  quot;
  logic [VALUE_W-1:0]  tenths;
  result_t             res_new;

  assign res_full   = (res_cnt_r == (RESQ_PTR_W+1)'(RESQ_DEPTH));
  assign res_empty  = (res_cnt_r == '0);
  assign res_do_pop = res_pop && !res_empty;
  assign res_head   = res_mem_r[res_rd_r];

  assign go      = !cmd_empty && !res_full;
  assign cmd_pop = go;

  // Channel lookup
  assign ch_idx    = cmd.ch[CH_IDX_W-1:0];
  assign in_range  = ({1'b0, cmd.ch} < 5'(CHANNELS));
  assign kind      = kinds_r[{cmd.ch, 1'b0} +: 2];
  assign cur_value = value_r[ch_idx];
  assign cur_errs  = errs_r[ch_idx];
  assign cur_timer = timer_r[ch_idx];

  // Raw reading times ten over sixteen, truncated toward zero
  assign raw    = {cmd.bytes[55:48], cmd.bytes[63:56]};
  assign r_ext  = {{4{raw[15]}}, raw};
  assign prod   = (r_ext <<< 3) + (r_ext <<< 1);
  assign quot   = (prod + (prod[19] ? 20'sd15 : 20'sd0)) >>> 4;
  assign tenths = {{(VALUE_W-20){quot[19]}}, quot};

  // Channel update by kind
  always_comb begin
    value_nxt = cur_value;
    errs_nxt  = cur_errs;
    timer_nxt = cur_timer;
    case (kind)
      KIND_TEMP: begin
        if (cmd.ok) begin
          value_nxt = tenths;
          errs_nxt  = '0;
        end else if (cur_errs < err_limit_r) begin
          errs_nxt = cur_errs + 1'b1;
        end else begin
          value_nxt = TEMP_ERROR_CODE;
        end
      end
      KIND_KEY: begin
        if (cmd.bytes == KEY_EMPTY) begin
          if (cur_timer != '0) begin
            timer_nxt = cur_timer - 1'b1;
          end else begin
            value_nxt = KEY_EMPTY;
            timer_nxt = hold_count_r;
          end
        end else begin
          value_nxt = cmd.bytes;
        end
      end
      default: begin
        value_nxt = cur_value;
      end
    endcase
  end

  // Result beat
  always_comb begin
    res_new.ch     = cmd.ch;
    res_new.crc_ok = cmd.ok;
    if (in_range) begin
      res_new.value  = value_nxt;
      res_new.errors = errs_nxt;
    end else begin
      res_new.value  = '0;
      res_new.errors = '0;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kinds_r      <= '0;
      err_limit_r  <= 8'd3;
      hold_count_r <= 16'd10;
    end else if (cfg.wr) begin
      case (cfg.index)
        REG_DEVICE_KINDS:   kinds_r      <= cfg.data;
        REG_ERROR_LIMIT:    err_limit_r  <= cfg.data[ERR_W-1:0];
        REG_KEY_HOLD_COUNT: hold_count_r <= cfg.data[HOLD_W-1:0];
        default: begin
          kinds_r <= kinds_r;
        end
      endcase
    end
  end

  // Channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        value_r[i] <= '0;
        errs_r[i]  <= '0;
        timer_r[i] <= '0;
      end
    end else if (go && in_range) begin
      value_r[ch_idx] <= value_nxt;
      errs_r[ch_idx]  <= errs_nxt;
      timer_r[ch_idx] <= timer_nxt;
    end
  end

  // Result queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_wr_r  <= '0;
      res_rd_r  <= '0;
      res_cnt_r <= '0;
    end else begin
      if (go) begin
        res_wr_r <= (res_wr_r == RESQ_PTR_W'(RESQ_DEPTH - 1)) ? '0 : res_wr_r + 1'b1;
      end
      if (res_do_pop) begin
        res_rd_r <= (res_rd_r == RESQ_PTR_W'(RESQ_DEPTH - 1)) ? '0 : res_rd_r + 1'b1;
      end
      if (go && !res_do_pop) begin
        res_cnt_r <= res_cnt_r + 1'b1;
      end else if (res_do_pop && !go) begin
        res_cnt_r <= res_cnt_r - 1'b1;
      end
    end
  end

  // Result queue storage
  always_ff @(posedge clk) begin
    if (go) begin
      res_mem_r[res_wr_r] <= res_new;
    end
  end

endmodule

>>> hw/rtl/onewire_frame_checker.sv
// Top level of the 1-Wire frame checker: front end, command queue and back end.
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------------
//  in       | in_push / in_full    | in_channel, in_frame_byte
//  out      | out_pop / out_empty  | out_result_channel, out_stored_value,
//           |                      | out_crc_ok, out_error_count
//  cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A byte beat is taken every cycle while in_full is low; a frame of nine beats yields
// one result, which reaches the out ports through the command queue and then the result
// queue; the back end updates the channel from the command queue head as it writes the result.
// in_full rises only on a closing byte while the command queue is full.
// Reset is synchronous and clears all channel state; cfg_ready is always high.
module onewire_frame_checker import ofc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  input  logic [CH_W-1:0]           in_channel,
  input  logic [BYTE_W-1:0]         in_frame_byte,
  output logic                      in_full,
  input  logic                      out_pop,
  output logic                      out_empty,
  output logic [CH_W-1:0]           out_result_channel,
  output logic signed [VALUE_W-1:0] out_stored_value,
  output logic                      out_crc_ok,
  output logic [ERR_W-1:0]          out_error_count,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  frame_cmd_t front_cmd;
  frame_cmd_t q_head;
  logic       front_push;
  logic       q_full;
  logic       q_empty;
  logic       q_pop;
  cfg_wr_t    cfg;
  result_t    res_head;

  // Configuration is always accepted
  assign cfg_ready = 1'b1;
  assign cfg.wr    = cfg_valid && cfg_ready;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  ofc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_channel    (in_channel),
    .in_frame_byte (in_frame_byte),
    .in_full       (in_full),
    .cmd_push      (front_push),
    .cmd           (front_cmd),
    .cmd_full      (q_full)
  );

  ofc_cmd_queue u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_push),
    .push_data (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  ofc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (q_head),
    .cmd_empty (q_empty),
    .cmd_pop   (q_pop),
    .res_pop   (out_pop),
    .res_head  (res_head),
    .res_empty (out_empty)
  );

  // Result fields
  assign out_result_channel = res_head.ch;
  assign out_stored_value   = res_head.value;
  assign out_crc_ok         = res_head.crc_ok;
  assign out_error_count    = res_head.errors;

endmodule

>>> hw/rtl/ofc_checker.sv
// Port-level checker for the 1-Wire frame checker and its bind.
module ofc_checker import ofc_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_push,
  input logic                      in_full,
  input logic                      out_pop,
  input logic                      out_empty,
  input logic [CH_W-1:0]           out_result_channel,
  input logic signed [VALUE_W-1:0] out_stored_value
);

  // Nothing is waiting right after reset
  a_empty_after_reset: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result waiting right after reset");

  // Input backpressure implies a backed-up result side
  a_full_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> !out_empty)
    else $error("input full while no result waits");

  // Input only fills up after a byte beat
  a_full_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_full) |-> $past(in_push && !in_full))
    else $error("input full without a preceding byte beat");

  // A waiting result holds until popped
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_stored_value)
                                  && $stable(out_result_channel)))
    else $error("waiting result changed before pop");

endmodule

bind onewire_frame_checker ofc_checker u_ofc_checker (.*);

>>> tb/sv/testbench.sv
// Self-checking testbench for the 1-Wire frame checker: directed frames, then random phases.
`timescale 1ns / 1ps

module testbench;
  import ofc_pkg::*;

  localparam int STALL_LIMIT = 1000;

  // Clock, reset and block inputs, all known from time zero
  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  in_push       = 1'b0;
  logic [CH_W-1:0]       in_channel    = '0;
  logic [BYTE_W-1:0]     in_frame_byte = '0;
  logic                  out_pop       = 1'b0;
  logic                  cfg_valid     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;

  logic                      in_full;
  logic                      out_empty;
  logic [CH_W-1:0]           out_result_channel;
  logic signed [VALUE_W-1:0] out_stored_value;
  logic                      out_crc_ok;
  logic [ERR_W-1:0]          out_error_count;
  logic                      cfg_ready;

  always #4 clk = ~clk;

  onewire_frame_checker u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_channel         (in_channel),
    .in_frame_byte      (in_frame_byte),
    .in_full            (in_full),
    .out_pop            (out_pop),
    .out_empty          (out_empty),
    .out_result_channel (out_result_channel),
    .out_stored_value   (out_stored_value),
    .out_crc_ok         (out_crc_ok),
    .out_error_count    (out_error_count),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // Register copies kept by the predictor
  logic [KINDS_W-1:0] dev_kinds   = '0;
  logic [ERR_W-1:0]   err_limit   = 8'd3;
  logic [HOLD_W-1:0]  hold_reload = 16'd10;

  // Frame assembly and per-channel state
  logic [3:0]         frame_pos   = '0;
  logic [BYTE_W-1:0]  frame_crc   = '0;
  logic [VALUE_W-1:0] frame_bytes = '0;
  logic [VALUE_W-1:0] ch_value  [CHANNELS];
  logic [ERR_W-1:0]   ch_errors [CHANNELS];
  logic [HOLD_W-1:0]  ch_hold   [CHANNELS];

  result_t pending_results [$];
  result_t typed_result;
  bit      use_typed = 1'b0;

  int n_errors  = 0;
  int n_checked = 0;
  int n_frames  = 0;
  int n_cfg     = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  initial begin
    for (int c = 0; c < CHANNELS; c++) begin
      ch_value[c]  = '0;
      ch_errors[c] = '0;
      ch_hold[c]   = '0;
    end
  end

  // Directed frames; rows marked typed_in carry their expected result
  typedef struct packed {
    logic [CH_W-1:0]    ch;
    logic [VALUE_W-1:0] data;
    logic               crc_good;
    logic               typed_in;
    logic [VALUE_W-1:0] exp_value;
    logic [ERR_W-1:0]   exp_errs;
  } dir_row_t;

  dir_row_t dir_rows [21] = '{
    // kinds still at reset: channel reports zeros
    '{4'd7,  64'h0123_4567_89AB_CDEF, 1'b1, 1'b1, 64'd0, 8'd0},
    // temperature conversions: +85.0, max, min, -1/16 rounds to zero, -0.5
    '{4'd0,  64'h5005_0000_0000_0000, 1'b1, 1'b1, 64'd850, 8'd0},
    '{4'd0,  64'hFF7F_FFFF_FFFF_FFFF, 1'b1, 1'b1, 64'd20479, 8'd0},
    '{4'd1,  64'h0080_1234_5678_9ABC, 1'b1, 1'b1, -64'sd20480, 8'd0},
    '{4'd1,  64'hFFFF_0000_0000_0000, 1'b1, 1'b1, 64'd0, 8'd0},
    '{4'd1,  64'hF8FF_AA55_AA55_AA55, 1'b1, 1'b1, -64'sd5, 8'd0},
    // CRC failures count up to the limit, then the error code is stored
    '{4'd0,  64'h1111_2222_3333_4444, 1'b0, 1'b1, 64'd20479, 8'd1},
    '{4'd0,  64'h1111_2222_3333_4444, 1'b0, 1'b1, 64'd20479, 8'd2},
    '{4'd0,  64'h1111_2222_3333_4444, 1'b0, 1'b1, TEMP_ERROR_CODE, 8'd2},
    '{4'd0,  64'h0000_0000_0000_0000, 1'b1, 1'b1, 64'd0, 8'd0},
    // key reads: CRC ignored, empty reads held off by the down-counter
    '{4'd2,  64'h0102_0304_0506_0708, 1'b0, 1'b1, 64'h0102_0304_0506_0708, 8'd0},
    '{4'd2,  KEY_EMPTY,               1'b1, 1'b1, KEY_EMPTY, 8'd0},
    '{4'd2,  64'h0000_0000_0000_0000, 1'b1, 1'b1, 64'd0, 8'd0},
    '{4'd2,  KEY_EMPTY,               1'b1, 1'b1, 64'd0, 8'd0},
    '{4'd2,  KEY_EMPTY,               1'b1, 1'b1, 64'd0, 8'd0},
    '{4'd2,  KEY_EMPTY,               1'b1, 1'b1, KEY_EMPTY, 8'd0},
    // kind other and kind none leave the channel alone; ch15 converts a temperature
    '{4'd3,  64'hDEAD_BEEF_0000_FFFF, 1'b1, 1'b1, 64'd0, 8'd0},
    '{4'd4,  64'h8000_0000_0000_0001, 1'b0, 1'b1, 64'd0, 8'd0},
    '{4'd15, 64'h9101_FFFF_FFFF_FFFF, 1'b1, 1'b1, 64'd250, 8'd0},
    // predictor-checked
    '{4'd1,  64'h3412_7E81_C3A5_5A0F, 1'b1, 1'b0, 64'd0, 8'd0},
    '{4'd0,  64'h6AFE_0919_2837_4655, 1'b0, 1'b0, 64'd0, 8'd0}
  };

  // Reflected CRC-8, one bit at a time
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ b[k];
      c  = {1'b0, c[7:1]};
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function automatic logic [7:0] crc_of_bytes(input logic [63:0] data);
    logic [7:0] c;
    c = '0;
    for (int i = 0; i < 8; i++) c = crc8_next(c, data[63-8*i -: 8]);
    return c;
  endfunction

  // Advance the predictor by one byte; returns 1 when a frame completes
  function automatic bit track_frame_byte(input logic [3:0] c, input logic [7:0] b,
                                          output result_t r);
    logic       ok;
    logic [1:0] kind;
    int         raw;
    r = '0;
    if (frame_pos < LAST_POS) begin
      frame_crc   = crc8_next(frame_crc, b);
      frame_bytes = {frame_bytes[55:0], b};
      frame_pos   = frame_pos + 4'd1;
      return 1'b0;
    end
    ok   = (frame_crc == b);
    kind = dev_kinds[2*c +: 2];
    case (kind)
      KIND_TEMP: begin
        if (ok) begin
          raw = $signed({frame_bytes[55:48], frame_bytes[63:56]});
          ch_value[c]  = longint'((raw * 10) / 16);
          ch_errors[c] = '0;
        end else if (ch_errors[c] < err_limit) begin
          ch_errors[c] = ch_errors[c] + 8'd1;
        end else begin
          ch_value[c] = TEMP_ERROR_CODE;
        end
      end
      KIND_KEY: begin
        if (frame_bytes != KEY_EMPTY) begin
          ch_value[c] = frame_bytes;
        end else if (ch_hold[c] != 0) begin
          ch_hold[c] = ch_hold[c] - 16'd1;
        end else begin
          ch_value[c] = KEY_EMPTY;
          ch_hold[c]  = hold_reload;
        end
      end
      default: ;
    endcase
    r.ch     = c;
    r.value  = ch_value[c];
    r.crc_ok = ok;
    r.errors = ch_errors[c];
    frame_pos   = '0;
    frame_crc   = '0;
    frame_bytes = '0;
    return 1'b1;
  endfunction

  // Push one byte beat; sender runs in bursts with random gaps
  task automatic push_byte(input logic [3:0] c, input logic [7:0] b);
    result_t r;
    int      gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_push       <= 1'b1;
    in_channel    <= c;
    in_frame_byte <= b;
    @(posedge clk);
    while (in_full) @(posedge clk);
    burst_left--;
    if (track_frame_byte(c, b, r)) pending_results.push_back(use_typed ? typed_result : r);
  endtask

  // Eight data bytes on noisy channels, then the closing CRC byte
  task automatic send_frame(input logic [3:0] c, input logic [63:0] data,
                            input logic [7:0] crc_b);
    for (int i = 0; i < 8; i++) push_byte(4'($urandom_range(0, 15)), data[63-8*i -: 8]);
    push_byte(c, crc_b);
    n_frames++;
  endtask

  // Hold the sender until every expected result is back
  task automatic wait_idle();
    in_push <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(input logic [31:0] kinds, input logic [7:0] lim,
                            input logic [15:0] hold);
    logic [CFG_IDX_W-1:0]  idx  [3];
    logic [CFG_DATA_W-1:0] vals [3];
    idx  = '{REG_DEVICE_KINDS, REG_ERROR_LIMIT, REG_KEY_HOLD_COUNT};
    vals = '{kinds, {24'd0, lim}, {16'd0, hold}};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (idx[i])
        REG_DEVICE_KINDS:   dev_kinds   = vals[i];
        REG_ERROR_LIMIT:    err_limit   = vals[i][7:0];
        REG_KEY_HOLD_COUNT: hold_reload = vals[i][15:0];
        default: ;
      endcase
      n_cfg++;
    end
    cfg_valid <= 1'b0;
  endtask

  // Result side: stall pattern rotates, refreshed each time pat_age wraps to zero
  logic [15:0] pop_pat = 16'hFFFF;
  int          pat_age = 0;

  always @(posedge clk) begin : pop_side
    result_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: channel %0d value %0d", $time,
                 out_result_channel, out_stored_value);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (want.ch !== out_result_channel) begin
          $display("%0t: channel mismatch: expected %0d, got %0d", $time,
                   want.ch, out_result_channel);
          n_errors++;
        end
        if (want.value !== out_stored_value) begin
          $display("%0t: value mismatch (ch %0d): expected %0d, got %0d", $time,
                   want.ch, want.value, out_stored_value);
          n_errors++;
        end
        if (want.crc_ok !== out_crc_ok) begin
          $display("%0t: crc_ok mismatch (ch %0d): expected %0b, got %0b", $time,
                   want.ch, want.crc_ok, out_crc_ok);
          n_errors++;
        end
        if (want.errors !== out_error_count) begin
          $display("%0t: error count mismatch (ch %0d): expected %0d, got %0d", $time,
                   want.ch, want.errors, out_error_count);
          n_errors++;
        end
      end
    end
    if (pat_age == 0)
      pop_pat = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
    pat_age = (pat_age + 1) % 48;
    out_pop <= rst_n & pop_pat[0];
    pop_pat = {pop_pat[0], pop_pat[15:1]};
  end

  // Watchdog: any accepted beat resets the count
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles, %0d results outstanding", $time,
               idle_cycles, pending_results.size());
      $display("[onewire_frame_checker] ERROR");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  // Main stimulus
  initial begin : stimulus
    logic [3:0]  c;
    logic [63:0] data;
    logic [7:0]  good;
    logic [7:0]  crc_b;
    logic [1:0]  kind;
    logic [15:0] raw;
    int          frames;
    int          pick;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows; the first runs with reset register values
    foreach (dir_rows[i]) begin
      if (i == 1) begin
        wait_idle();
        // ch0/ch1/ch15 temperature, ch2 key, ch3 other, rest none
        write_regs(32'h4000_00E5, 8'd2, 16'd2);
      end
      good = crc_of_bytes(dir_rows[i].data);
      use_typed           = dir_rows[i].typed_in;
      typed_result.ch     = dir_rows[i].ch;
      typed_result.value  = dir_rows[i].exp_value;
      typed_result.crc_ok = dir_rows[i].crc_good;
      typed_result.errors = dir_rows[i].exp_errs;
      send_frame(dir_rows[i].ch, dir_rows[i].data, dir_rows[i].crc_good ? good : good ^ 8'h5A);
    end
    use_typed = 1'b0;

    // Random phases, each under its own register setting
    for (int p = 0; p < 5; p++) begin
      wait_idle();
      case (p)
        0: write_regs($urandom, 8'd0, 16'd0);
        1: write_regs(32'hFFFF_FFFF, 8'd255, 16'hFFFF);
        2: write_regs(32'h5555_5555, 8'd3, 16'd10);
        3: write_regs(32'hAAAA_AAAA, 8'd1, 16'd3);
        default: write_regs($urandom, 8'($urandom_range(1, 4)), 16'($urandom_range(0, 5)));
      endcase
      frames = (p == 1) ? 4 : (p == 4) ? 5 : 7;
      for (int f = 0; f < frames; f++) begin
        // favor a few channels so per-channel history builds up
        c    = ($urandom_range(0, 1) == 1) ? 4'($urandom_range(0, 3))
                                           : 4'($urandom_range(0, 15));
        kind = dev_kinds[2*c +: 2];
        data = {$urandom, $urandom};
        pick = $urandom_range(0, 9);
        if (kind == KIND_KEY && pick < 4) data = KEY_EMPTY;
        if (kind == KIND_TEMP && pick < 3) begin
          case ($urandom_range(0, 4))
            0: raw = 16'h7FFF;
            1: raw = 16'h8000;
            2: raw = 16'hFFFF;
            3: raw = 16'h0000;
            default: raw = 16'hFFF0;
          endcase
          data[63:48] = {raw[7:0], raw[15:8]};
        end
        good = crc_of_bytes(data);
        pick = $urandom_range(0, 19);
        if (pick < 15) crc_b = good;
        else if (pick < 19) crc_b = good ^ 8'($urandom_range(1, 255));
        else crc_b = 8'($urandom);
        send_frame(c, data, crc_b);
      end
    end

    wait_idle();
    repeat (4) @(posedge clk);
    $display("Run covered %0d frames (%0d directed) under reset and 6 written settings, %0d writes;",
             n_frames, $size(dir_rows), n_cfg);
    $display("%0d results checked, %0d mismatches.", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("[onewire_frame_checker] OK");
    end else begin
      $display("[onewire_frame_checker] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/ofc_pkg.sv
hw/rtl/ofc_front.sv
hw/rtl/ofc_cmd_queue.sv
hw/rtl/ofc_back.sv
hw/rtl/onewire_frame_checker.sv
hw/rtl/ofc_checker.sv
tb/sv/testbench.sv
